// File: rtl/core/vpr_pkg.sv
// ----------------------------------------------------------------------------
// vpr_pkg
// Shared types and constants of the VPW pulse receiver.
// ----------------------------------------------------------------------------
package vpr_pkg;

    localparam int PULSE_W = 16;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] BYTE_SCRAMBLE = 8'h55;

    localparam logic [CFG_IDX_W-1:0] CFG_SOF_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MID       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 3'd4;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_BUSERR = 2'd2,
        KIND_NOSOF  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [PULSE_W-1:0] sof_min;
        logic [PULSE_W-1:0] short_min;
        logic [PULSE_W-1:0] long_max;
        logic [PULSE_W-1:0] mid;
    } width_cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic timeout;
        logic sof_ok;
        logic bad_width;
        logic bit_val;
    } pulse_cls_t;

endpackage

// File: rtl/core/vpr_front.sv
// ----------------------------------------------------------------------------
// vpr_front
// Classifies an incoming word against the width thresholds.
// ----------------------------------------------------------------------------
module vpr_front #(
    parameter int WIDTH_BITS = 16
) (
    input  logic                         command,
    input  logic [vpr_pkg::PULSE_W-1:0]  pulse_width,
    input  vpr_pkg::width_cfg_t          cfg,
    output vpr_pkg::pulse_cls_t          cls
);

    localparam int EFF_W = (WIDTH_BITS < vpr_pkg::PULSE_W) ? WIDTH_BITS : vpr_pkg::PULSE_W;
    localparam logic [vpr_pkg::PULSE_W-1:0] WMASK =
        vpr_pkg::PULSE_W'((33'h1 << EFF_W) - 33'h1);

    logic [vpr_pkg::PULSE_W-1:0] width;

    always_comb
    begin
        width         = pulse_width & WMASK;
        cls.timeout   = command;
        cls.sof_ok    = (width >= cfg.sof_min);
        cls.bad_width = (width < cfg.short_min) || (width > cfg.long_max);
        cls.bit_val   = (width > cfg.mid);
    end

endmodule

// File: rtl/core/vpr_queue.sv
// ----------------------------------------------------------------------------
// vpr_queue
// Two-entry queue between the classifier and the frame decoder.
// ----------------------------------------------------------------------------
module vpr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vpr_pkg::pulse_cls_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output vpr_pkg::pulse_cls_t  head
);

    vpr_pkg::pulse_cls_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;

    assign full      = (level_reg == 2'd2);
    assign not_empty = (level_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// File: rtl/core/vpr_back.sv
// ----------------------------------------------------------------------------
// vpr_back
// Frame decoder: assembles bits into bytes and registers each result word.
// ----------------------------------------------------------------------------
module vpr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  vpr_pkg::pulse_cls_t           q_head,
    output logic                          q_pop,
    input  logic [vpr_pkg::COUNT_W-1:0]   limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [7:0]                    data_byte,
    output logic [vpr_pkg::COUNT_W-1:0]   byte_count,
    output logic                          frame_end
);

    logic                        in_frame_reg, in_frame_next;
    logic [2:0]                  bit_idx_reg, bit_idx_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [vpr_pkg::COUNT_W-1:0] rcv_cnt_reg, rcv_cnt_next;

    logic                        out_valid_reg, out_valid_next;
    vpr_pkg::kind_t              kind_reg, kind_next;
    logic [7:0]                  data_reg, data_next;
    logic [vpr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        end_reg, end_next;

    logic                        emit;
    logic [7:0]                  shifted;
    logic [vpr_pkg::COUNT_W-1:0] cnt_inc;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data_byte  = data_reg;
    assign byte_count = count_reg;
    assign frame_end  = end_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        rcv_cnt_next  = rcv_cnt_reg;
        kind_next     = kind_reg;
        data_next     = data_reg;
        count_next    = count_reg;
        end_next      = end_reg;
        emit          = 1'b0;
        shifted       = {shift_reg[6:0], q_head.bit_val};
        cnt_inc       = rcv_cnt_reg + 7'd1;

        if (q_pop)
        begin
            if (!in_frame_reg)
            begin
                if (q_head.timeout)
                begin
                    emit       = 1'b1;
                    kind_next  = vpr_pkg::KIND_NOSOF;
                    data_next  = 8'd0;
                    count_next = '0;
                    end_next   = 1'b0;
                end
                else if (q_head.sof_ok)
                begin
                    in_frame_next = 1'b1;
                    bit_idx_next  = 3'd0;
                    shift_next    = 8'd0;
                    rcv_cnt_next  = '0;
                end
            end
            else if (q_head.timeout || q_head.bad_width)
            begin
                emit          = 1'b1;
                kind_next     = q_head.timeout ? vpr_pkg::KIND_DONE : vpr_pkg::KIND_BUSERR;
                data_next     = 8'd0;
                count_next    = rcv_cnt_reg;
                end_next      = 1'b1;
                in_frame_next = 1'b0;
                bit_idx_next  = 3'd0;
                shift_next    = 8'd0;
                rcv_cnt_next  = '0;
            end
            else if (bit_idx_reg != 3'd7)
            begin
                shift_next   = shifted;
                bit_idx_next = bit_idx_reg + 3'd1;
            end
            else
            begin
                emit         = 1'b1;
                kind_next    = vpr_pkg::KIND_DATA;
                data_next    = shifted ^ vpr_pkg::BYTE_SCRAMBLE;
                count_next   = cnt_inc;
                end_next     = (cnt_inc >= limit);
                bit_idx_next = 3'd0;
                shift_next   = 8'd0;
                if (cnt_inc >= limit)
                begin
                    in_frame_next = 1'b0;
                    rcv_cnt_next  = '0;
                end
                else
                begin
                    rcv_cnt_next = cnt_inc;
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            count_reg <= count_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            bit_idx_reg   <= 3'd0;
            shift_reg     <= 8'd0;
            rcv_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            rcv_cnt_reg   <= rcv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/vpw_pulse_receiver_unit.sv
// ----------------------------------------------------------------------------
// vpw_pulse_receiver_unit
// VPW frame receiver working on measured pulse widths and timeout events.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid/in_ready, command, pulse_width  | in
//  out     | out_valid/out_ready, kind, data_byte,    | out
//          | byte_count, frame_end                    |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | in
//
//  One word per cycle sustained while out_ready holds; an accepted word is
//  classified into the queue, then decoded into the output register.
//  The word rate is set by the decoder step on the queue head.
//  While a result waits on out_ready the two-entry queue fills up,
//  then in_ready drops until the result leaves.
//  Reset restores threshold defaults and drops any open frame.
// ----------------------------------------------------------------------------
module vpw_pulse_receiver_unit #(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int WIDTH_BITS      = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [vpr_pkg::PULSE_W-1:0]     pulse_width,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [7:0]                      data_byte,
    output logic [vpr_pkg::COUNT_W-1:0]     byte_count,
    output logic                            frame_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vpr_pkg::PULSE_W-1:0]     cfg_data
);

    localparam logic [7:0] MAXB = 8'(MAX_FRAME_BYTES);

    vpr_pkg::width_cfg_t         cfg_reg;
    logic [vpr_pkg::COUNT_W-1:0] max_bytes_reg;
    logic [7:0]                  limit_w;
    logic [vpr_pkg::COUNT_W-1:0] limit;

    vpr_pkg::pulse_cls_t         cls;
    vpr_pkg::pulse_cls_t         q_head;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic                        push;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;

    always_comb
    begin
        limit_w = (max_bytes_reg == '0) ? 8'd1 : {1'b0, max_bytes_reg};
        if (limit_w > MAXB)
        begin
            limit_w = MAXB;
        end
        limit = limit_w[vpr_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_min   <= 16'd163;
            cfg_reg.short_min <= 16'd34;
            cfg_reg.long_max  <= 16'd163;
            cfg_reg.mid       <= 16'd96;
            max_bytes_reg     <= 7'd12;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vpr_pkg::CFG_SOF_MIN:   cfg_reg.sof_min   <= cfg_data;
                vpr_pkg::CFG_SHORT_MIN: cfg_reg.short_min <= cfg_data;
                vpr_pkg::CFG_LONG_MAX:  cfg_reg.long_max  <= cfg_data;
                vpr_pkg::CFG_MID:       cfg_reg.mid       <= cfg_data;
                vpr_pkg::CFG_MAX_BYTES: max_bytes_reg     <= cfg_data[vpr_pkg::COUNT_W-1:0];
                default:                ;
            endcase
        end
    end

    vpr_front #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_front (
        .command     (command),
        .pulse_width (pulse_width),
        .cfg         (cfg_reg),
        .cls         (cls)
    );

    vpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    vpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .limit      (limit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data_byte  (data_byte),
        .byte_count (byte_count),
        .frame_end  (frame_end)
    );

    // no-SOF report never carries frame information
    a_nosof_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == vpr_pkg::KIND_NOSOF) |-> !frame_end && (byte_count == '0))
        else $error("no-SOF result carries frame data");

    // timeout and bus error inside a frame always close it
    a_close_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == vpr_pkg::KIND_DONE) || (kind == vpr_pkg::KIND_BUSERR))
        |-> frame_end)
        else $error("frame end missing on close");

    // byte count never passes the frame size limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, byte_count} <= MAXB))
        else $error("byte count beyond frame limit");

    // a word is pulled from the queue only when the queue holds one
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
